>>> rtl/core/hsirgb_pkg.sv
// ----------------------------------------------------------------------------
// hsirgb_pkg
// Constants shared by the hsi to rgb converter: angle scaling, q30 unity,
// series divisors and pipeline sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package hsirgb_pkg;

    localparam int unsigned HUE_BITS_DEFAULT = 12;

    localparam int unsigned HUE_W = 12;
    localparam int unsigned SAT_W = 9;
    localparam int unsigned INT_W = 9;
    localparam int unsigned CH_W  = 8;
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 24;

    // q30 fixed point
    localparam int unsigned ANG_W = 32;
    localparam int unsigned Q30_W = 31;
    localparam logic [Q30_W-1:0] Q30_ONE = 31'h4000_0000;

    localparam logic [ANG_W-1:0] ANG_SECTOR   = 32'd2248839617;
    localparam logic [ANG_W-1:0] ANG_THIRD_PI = 32'd1124419809;
    localparam logic [ANG_W-1:0] ANG_HALF_PI  = 32'd1686629713;

    // horner series divisors
    localparam int unsigned COS_STEPS = 5;
    localparam int unsigned SIN_STEPS = 4;
    localparam int unsigned COS_DIV [COS_STEPS] = '{90, 56, 30, 12, 2};
    localparam int unsigned SIN_DIV [SIN_STEPS] = '{72, 42, 20, 6};
    localparam int unsigned STEP_STAGES = 3;

    // quotient bits of the ratio divider
    localparam int unsigned RATIO_QB = 19;

endpackage

`default_nettype wire

>>> rtl/core/hsirgb_horner_step.sv
// ----------------------------------------------------------------------------
// hsirgb_horner_step
// One series step r' = 1 - floor(x2*r / (n*2^30)), saturating at zero, in
// three register stages; the constant divide is a reciprocal multiply with
// a single correction.
// ----------------------------------------------------------------------------
`default_nettype none

module hsirgb_horner_step #(
    parameter int unsigned N = 2
) (
    input  wire logic                             aclk,
    input  wire logic                             ce,
    input  wire logic [hsirgb_pkg::ANG_W-1:0]     x2_in,
    input  wire logic [hsirgb_pkg::Q30_W-1:0]     r_in,
    output logic      [hsirgb_pkg::ANG_W-1:0]     x2_out,
    output logic      [hsirgb_pkg::Q30_W-1:0]     r_out
);

    localparam int unsigned K = 34;
    localparam logic [34:0] M = 35'((64'd1 << K) / N);

    logic [32:0] v1_reg, v2_reg;
    logic [32:0] q0_reg;
    logic [31:0] x2a_reg, x2b_reg, x2c_reg;
    logic [30:0] r_reg;

    logic [62:0] prod;
    logic [67:0] prodm;
    logic [39:0] qn;
    logic [39:0] rem;
    logic [33:0] q;
    logic [30:0] r_next;

    always_comb begin
        prod  = 63'(x2_in) * 63'(r_in);
        prodm = 68'(v1_reg) * 68'(M);
        qn    = 40'(q0_reg) * 40'(N);
        rem   = 40'(v2_reg) - qn;
        if (rem >= 40'(N)) begin
            q = 34'(q0_reg) + 34'd1;
        end else begin
            q = 34'(q0_reg);
        end
        if (q >= 34'(hsirgb_pkg::Q30_ONE)) begin
            r_next = '0;
        end else begin
            r_next = 31'(34'(hsirgb_pkg::Q30_ONE) - q);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            v1_reg  <= prod[62:30];
            x2a_reg <= x2_in;
            v2_reg  <= v1_reg;
            q0_reg  <= prodm[66:34];
            x2b_reg <= x2a_reg;
            r_reg   <= r_next;
            x2c_reg <= x2b_reg;
        end
    end

    assign x2_out = x2c_reg;
    assign r_out  = r_reg;

endmodule

`default_nettype wire

>>> rtl/core/hsi_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// hsi_to_rgb_converter_unit
// Converts one hsi pixel to an 8-bit rgb pixel.
//
// s_ channel: one pixel item (hue, saturation, intensity) per handshake.
// m_ channel: one rgb item per input item, in the same order.
// Throughput is one item per clock while the receiver does not stall. Latency
// from input handshake to m_tvalid is set by the series pipelines for the two
// cosines (five steps of three stages, 15 stages) and the one-bit-per-stage
// ratio divider (19 stages), plus the angle, channel and output stages.
// Reset (aresetn low, synchronous) empties the pipeline and drops m_tvalid.
// When the receiver stalls, the output register holds its item; the
// pipeline keeps advancing while its last stage is empty and freezes
// otherwise, so s_tready falls as soon as an item waits in the last stage
// behind the stalled output. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module hsi_to_rgb_converter_unit #(
    parameter int unsigned HUE_BITS = hsirgb_pkg::HUE_BITS_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // hue [11:0], saturation [20:12], intensity [29:21], zero fill
    input  wire logic [hsirgb_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // red [7:0], green [15:8], blue [23:16]
    output logic      [hsirgb_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int unsigned QB     = hsirgb_pkg::RATIO_QB;
    localparam int unsigned RW     = hsirgb_pkg::Q30_W + QB - 1;
    localparam int unsigned HORNER = 4;
    localparam int unsigned COS_END = HORNER + hsirgb_pkg::COS_STEPS * hsirgb_pkg::STEP_STAGES;
    localparam int unsigned SIN_END = HORNER + hsirgb_pkg::SIN_STEPS * hsirgb_pkg::STEP_STAGES;
    localparam int unsigned DIV0   = COS_END + 1;
    localparam int unsigned MUL0   = DIV0 + QB + 1;
    localparam int unsigned LAST   = MUL0 + 3;
    localparam int unsigned CW     = 42;

    typedef struct packed {
        logic [1:0]                       sector;
        logic [hsirgb_pkg::SAT_W-1:0]     sat;
        logic [hsirgb_pkg::INT_W-1:0]     inten;
        logic [hsirgb_pkg::ANG_W-1:0]     xn;
        logic                             neg;
    } side_t;

    side_t side_reg [0:LAST];
    side_t side_next [0:LAST];
    logic [LAST:0] v_reg;
    logic [LAST:0] v_next;
    logic          ce;
    logic          out_load;

    logic [HUE_BITS-1:0]    h_reg;
    logic [HUE_BITS+31:0]   prod1_reg;
    logic [31:0]            a_reg;
    logic [31:0]            xd_reg;
    logic [31:0]            x2n_reg, x2d_reg;
    logic [30:0]            sin_reg, sin_d1_reg, sin_d2_reg;
    logic [RW-1:0]          rem_reg [0:QB];
    logic [QB-1:0]          q_reg [0:QB];
    logic [30:0]            dv_reg [0:QB];
    logic signed [29:0]     sr_reg;
    logic signed [20:0]     lowm_reg;
    logic signed [CW-1:0]   lead_reg, low_reg, third0_reg;
    logic signed [CW-1:0]   ch_reg [0:2];
    logic [7:0]             byte_reg [0:2];
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [hsirgb_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [31:0] cn_x2 [0:hsirgb_pkg::COS_STEPS];
    logic [30:0] cn_r  [0:hsirgb_pkg::COS_STEPS];
    logic [31:0] cd_x2 [0:hsirgb_pkg::COS_STEPS];
    logic [30:0] cd_r  [0:hsirgb_pkg::COS_STEPS];
    logic [31:0] sn_x2 [0:hsirgb_pkg::SIN_STEPS];
    logic [30:0] sn_r  [0:hsirgb_pkg::SIN_STEPS];

    logic [31:0]          hue_ext;
    logic [HUE_BITS+1:0]  p1;
    logic [HUE_BITS+31:0] prod1_next;
    logic [HUE_BITS+31:0] a_sum;
    logic [31:0]          xn3;
    logic signed [32:0]   d3;
    logic [63:0]          sqn, sqd, sinp;
    logic [30:0]          mag20, den20;

    assign out_load = !m_tvalid_reg || m_tready;
    assign ce       = out_load || !v_reg[LAST];
    assign s_tready = ce;
    assign v_next   = {v_reg[LAST-1:0], s_tvalid};

    always_comb begin
        hue_ext    = {{(32-hsirgb_pkg::HUE_W){1'b0}}, s_tdata[hsirgb_pkg::HUE_W-1:0]};
        p1         = (HUE_BITS+2)'(h_reg) + {h_reg, 1'b0};
        prod1_next = (HUE_BITS+32)'(p1[HUE_BITS-1:0]) * (HUE_BITS+32)'(hsirgb_pkg::ANG_SECTOR);
        a_sum      = prod1_reg + ((HUE_BITS+32)'(1) << (HUE_BITS-1));
        if (a_reg <= hsirgb_pkg::ANG_HALF_PI) begin
            xn3 = a_reg;
        end else begin
            xn3 = a_reg - hsirgb_pkg::ANG_HALF_PI;
        end
        d3   = $signed({1'b0, hsirgb_pkg::ANG_THIRD_PI}) - $signed({1'b0, a_reg});
        sqn  = 64'(side_reg[3].xn) * 64'(side_reg[3].xn);
        sqd  = 64'(xd_reg) * 64'(xd_reg);
        sinp = 64'(side_reg[SIN_END].xn) * 64'(sn_r[hsirgb_pkg::SIN_STEPS]);
        mag20 = side_reg[COS_END].neg ? sin_d2_reg : cn_r[hsirgb_pkg::COS_STEPS];
        den20 = (cd_r[hsirgb_pkg::COS_STEPS] == '0) ? 31'd1 : cd_r[hsirgb_pkg::COS_STEPS];
    end

    always_comb begin
        side_next[0].sector = '0;
        side_next[0].sat    = s_tdata[20:12];
        side_next[0].inten  = s_tdata[29:21];
        side_next[0].xn     = '0;
        side_next[0].neg    = 1'b0;
        for (int k = 1; k <= LAST; k++) begin
            side_next[k] = side_reg[k-1];
        end
        side_next[1].sector = p1[HUE_BITS+1:HUE_BITS];
        side_next[3].xn     = xn3;
        side_next[3].neg    = (a_reg > hsirgb_pkg::ANG_HALF_PI);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k <= LAST; k++) begin
                side_reg[k] <= side_next[k];
            end
            h_reg      <= hue_ext[HUE_BITS-1:0];
            prod1_reg  <= prod1_next;
            a_reg      <= 32'(a_sum >> HUE_BITS);
            xd_reg     <= d3[32] ? 32'(-d3) : 32'(d3);
            x2n_reg    <= sqn[61:30];
            x2d_reg    <= sqd[61:30];
            sin_reg    <= sinp[60:30];
            sin_d1_reg <= sin_reg;
            sin_d2_reg <= sin_d1_reg;
        end
    end

    // series chains: cosine of num angle, sine of num angle, cosine of den angle
    assign cn_x2[0] = x2n_reg;
    assign cn_r[0]  = hsirgb_pkg::Q30_ONE;
    assign cd_x2[0] = x2d_reg;
    assign cd_r[0]  = hsirgb_pkg::Q30_ONE;
    assign sn_x2[0] = x2n_reg;
    assign sn_r[0]  = hsirgb_pkg::Q30_ONE;

    for (genvar g = 0; g < hsirgb_pkg::COS_STEPS; g++) begin : g_cos
        hsirgb_horner_step #(.N(hsirgb_pkg::COS_DIV[g])) u_num (
            .aclk(aclk), .ce(ce), .x2_in(cn_x2[g]), .r_in(cn_r[g]),
            .x2_out(cn_x2[g+1]), .r_out(cn_r[g+1])
        );
        hsirgb_horner_step #(.N(hsirgb_pkg::COS_DIV[g])) u_den (
            .aclk(aclk), .ce(ce), .x2_in(cd_x2[g]), .r_in(cd_r[g]),
            .x2_out(cd_x2[g+1]), .r_out(cd_r[g+1])
        );
    end

    for (genvar g = 0; g < hsirgb_pkg::SIN_STEPS; g++) begin : g_sin
        hsirgb_horner_step #(.N(hsirgb_pkg::SIN_DIV[g])) u_sin (
            .aclk(aclk), .ce(ce), .x2_in(sn_x2[g]), .r_in(sn_r[g]),
            .x2_out(sn_x2[g+1]), .r_out(sn_r[g+1])
        );
    end

    // restoring divider, one quotient bit per stage
    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0] <= RW'({mag20, 16'b0});
            q_reg[0]   <= '0;
            dv_reg[0]  <= den20;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int unsigned B = QB - 1 - j;
        logic [RW-1:0] trial;
        logic          ge;
        assign trial = RW'(dv_reg[j]) << B;
        assign ge    = (rem_reg[j] >= trial);
        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[j+1] <= ge ? rem_reg[j] - trial : rem_reg[j];
                q_reg[j+1]   <= q_reg[j] | (QB'(ge) << B);
                dv_reg[j+1]  <= dv_reg[j];
            end
        end
    end

    // channel arithmetic
    side_t sm;
    logic signed [QB:0]  ratio;
    logic signed [10:0]  one_minus_s;
    logic signed [9:0]   i_s;
    logic signed [30:0]  lead_f;
    logic signed [CW-1:0] third;
    side_t sc;
    logic [40:0] w [0:2];
    logic [7:0]  b_next [0:2];

    always_comb begin
        sm = side_reg[MUL0-1];
        sc = side_reg[MUL0+1];
        ratio = sm.neg ? -$signed({1'b0, q_reg[QB]}) : $signed({1'b0, q_reg[QB]});
        one_minus_s = 11'sd256 - $signed({2'b0, sm.sat});
        i_s    = $signed({1'b0, side_reg[MUL0].inten});
        lead_f = 31'sd16777216 + 31'(sr_reg);
        third  = third0_reg - lead_reg - low_reg;
        for (int c = 0; c < 3; c++) begin
            w[c] = {1'b0, ch_reg[c][31:0], 8'b0} - 41'(ch_reg[c][31:0]) + 41'h0_8000_0000;
            if (ch_reg[c] <= 0) begin
                b_next[c] = '0;
            end else if (ch_reg[c] >= 42'sh1_0000_0000) begin
                b_next[c] = 8'hff;
            end else begin
                b_next[c] = w[c][39:32];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sr_reg     <= 30'($signed({1'b0, sm.sat})) * 30'(ratio);
            lowm_reg   <= 21'($signed({1'b0, sm.inten})) * 21'(one_minus_s);
            lead_reg   <= CW'(i_s) * CW'(lead_f);
            low_reg    <= CW'(lowm_reg) <<< 16;
            third0_reg <= CW'($signed({3'b0, side_reg[MUL0].inten}) * 13'sd3) <<< 24;
            unique case (sc.sector)
                2'd0: begin
                    ch_reg[0] <= lead_reg;
                    ch_reg[1] <= third;
                    ch_reg[2] <= low_reg;
                end
                2'd1: begin
                    ch_reg[0] <= low_reg;
                    ch_reg[1] <= lead_reg;
                    ch_reg[2] <= third;
                end
                default: begin
                    ch_reg[0] <= third;
                    ch_reg[1] <= low_reg;
                    ch_reg[2] <= lead_reg;
                end
            endcase
            for (int c = 0; c < 3; c++) begin
                byte_reg[c] <= b_next[c];
            end
        end
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = v_reg[LAST];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && v_reg[LAST]) begin
            m_tdata_reg <= {byte_reg[2], byte_reg[1], byte_reg[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && v_reg[LAST]) |-> !s_tready)
        else $error("pipeline advanced over a stalled item");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v_reg[0])
        else $error("accepted item not in first stage");

    a_den: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[DIV0] |-> (dv_reg[0] != '0))
        else $error("zero divisor reached the divider");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

>>> sim/tb_hsi_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// tb_hsi_to_rgb_converter_unit
// Self-checking bench for the hsi to rgb converter. Pixels go in on the s_
// stream in bursts with random gaps and the m_ stream stalls on its own
// pattern, with one long hold-off that fills the pipeline. Each rgb item is
// checked field by field against a fixed-point predictor of the conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hsi_to_rgb_converter_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HUE_W     = hsirgb_pkg::HUE_W;
    localparam int unsigned SAT_W     = hsirgb_pkg::SAT_W;
    localparam int unsigned INT_W     = hsirgb_pkg::INT_W;
    localparam int unsigned CH_W      = hsirgb_pkg::CH_W;
    localparam int unsigned S_TDATA_W = hsirgb_pkg::S_TDATA_W;
    localparam int unsigned M_TDATA_W = hsirgb_pkg::M_TDATA_W;
    localparam int unsigned LATENCY   = 44;
    localparam int unsigned IDLE_MAX  = 20000;
    localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
    localparam longint      ONE_Q32   = 64'sd1 << 32;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    rgb_t rgb_expected[$];
    int   fail_count;
    int   idle_cycles;
    bit   hold_off;
    bit   in_burst;
    int   burst_left;
    int   gap_left;

    hsi_to_rgb_converter_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] series_step(logic [63:0] x2, logic [63:0] r, int n);
        logic [63:0] q;
        q = (x2 * r) / (64'(n) << 30);
        return (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
    endfunction

    function automatic logic [63:0] cosine_q30(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] r;
        x2 = (x * x) >> 30;
        r = ONE_Q30;
        for (int k = 0; k < hsirgb_pkg::COS_STEPS; k++) begin
            r = series_step(x2, r, hsirgb_pkg::COS_DIV[k]);
        end
        return r;
    endfunction

    function automatic logic [63:0] sine_q30(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] r;
        x2 = (x * x) >> 30;
        r = ONE_Q30;
        for (int k = 0; k < hsirgb_pkg::SIN_STEPS; k++) begin
            r = series_step(x2, r, hsirgb_pkg::SIN_DIV[k]);
        end
        return (x * r) >> 30;
    endfunction

    function automatic logic [CH_W-1:0] channel_byte(longint v);
        logic [63:0] u;
        if (v <= 0) return '0;
        if (v >= ONE_Q32) return 8'd255;
        u = 64'(v);
        return CH_W'(((u * 64'd255) + (64'd1 << 31)) >> 32);
    endfunction

    function automatic rgb_t hsi_to_rgb(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                                        logic [INT_W-1:0] inten);
        logic [63:0] p;
        logic [63:0] t;
        logic [63:0] ang;
        logic [63:0] den;
        logic [63:0] mag;
        longint num;
        longint d;
        longint ratio;
        longint s;
        longint i;
        longint lead;
        longint low;
        longint third;
        rgb_t   px;
        p = 64'(hue) * 3;
        t = p & ((64'd1 << HUE_W) - 1);
        ang = (t * 64'(hsirgb_pkg::ANG_SECTOR) + (64'd1 << (HUE_W - 1))) >> HUE_W;
        if (ang <= 64'(hsirgb_pkg::ANG_HALF_PI)) num = longint'(cosine_q30(ang));
        else num = -longint'(sine_q30(ang - 64'(hsirgb_pkg::ANG_HALF_PI)));
        d = longint'(hsirgb_pkg::ANG_THIRD_PI) - longint'(ang);
        den = cosine_q30(64'(d < 0 ? -d : d));
        if (den == 0) den = 1;
        mag = 64'(num < 0 ? -num : num);
        ratio = longint'((mag << 16) / den);
        if (num < 0) ratio = -ratio;
        s = longint'(sat);
        i = longint'(inten);
        lead = i * ((64'sd1 <<< 24) + s * ratio);
        low = i * (256 - s) * 65536;
        third = i * 3 * (64'sd1 <<< 24) - lead - low;
        case (p >> HUE_W)
            0: begin
                px.red = channel_byte(lead); px.green = channel_byte(third);
                px.blue = channel_byte(low);
            end
            1: begin
                px.red = channel_byte(low); px.green = channel_byte(lead);
                px.blue = channel_byte(third);
            end
            default: begin
                px.red = channel_byte(third); px.green = channel_byte(low);
                px.blue = channel_byte(lead);
            end
        endcase
        return px;
    endfunction

    // one pixel, with burst and gap pacing
    task automatic send_pixel(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                              logic [INT_W-1:0] inten);
        while (!in_burst) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left--;
                @(posedge aclk);
            end else begin
                in_burst = 1'b1;
                burst_left = $urandom_range(1, 40);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W - HUE_W - SAT_W - INT_W){1'b0}}, inten, sat, hue};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        rgb_expected.push_back(hsi_to_rgb(hue, sat, inten));
        burst_left--;
        if (burst_left == 0) begin
            in_burst = 1'b0;
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
    endtask

    task automatic test_directed();
        logic [HUE_W-1:0] hues[10] = '{12'd0, 12'd4095, 12'd1365, 12'd1366, 12'd2730,
                                       12'd2731, 12'd682, 12'd2048, 12'd1, 12'd3412};
        foreach (hues[k]) send_pixel(hues[k], 9'd256, 9'd256);
        send_pixel(12'd100, 9'd0, 9'd256);
        send_pixel(12'd100, 9'd256, 9'd0);
        send_pixel(12'd3000, 9'd511, 9'd511);
        send_pixel(12'd2000, 9'd511, 9'd128);
        send_pixel(12'd500, 9'd128, 9'd511);
        send_pixel(12'd0, 9'd0, 9'd0);
        send_pixel(12'd1200, 9'd257, 9'd257);
        send_pixel(12'd4000, 9'd1, 9'd1);
        send_pixel(12'd2500, 9'd200, 9'd300);
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 3))
                0: send_pixel(HUE_W'($urandom), SAT_W'($urandom), INT_W'($urandom));
                default: send_pixel(HUE_W'($urandom), SAT_W'($urandom_range(0, 256)),
                                    INT_W'($urandom_range(0, 256)));
            endcase
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            test_random(120);
        join
    endtask

    task automatic drain();
        while (rgb_expected.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // receiver stall pattern
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off) m_tready <= 1'b0;
            else if ((($time / 10) % 200) < 60) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result checker
    initial begin
        rgb_t got;
        rgb_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = rgb_t'({m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]});
                if (rgb_expected.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = rgb_expected.pop_front();
                    if (got.red !== want.red) begin
                        $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
                        fail_count++;
                    end
                    if (got.green !== want.green) begin
                        $display("%0t: green expected %0d actual %0d", $time,
                                 want.green, got.green);
                        fail_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $display("%0t: blue expected %0d actual %0d", $time,
                                 want.blue, got.blue);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_MAX) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        fail_count = 0;
        hold_off = 1'b0;
        in_burst = 1'b0;
        gap_left = 0;
        burst_left = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(1400);
        s_tvalid <= 1'b0;
        drain();
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
